// File: src/msta_pkg.sv
// ----------------------------------------------------------------------------
// msta_pkg
// Shared widths, operation codes and the broadcast bus type of the alarm cells.
// ----------------------------------------------------------------------------
package msta_pkg;

    localparam int SLOT_W        = 6;
    localparam int DELAY_W       = 16;
    localparam int TICK_W        = 32;
    localparam int NUM_SLOTS_DEF = 64;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ARM  = 1'b1;

    // broadcast from control to every cell
    typedef struct packed {
        logic              wr;      // arm write to the addressed cell
        logic              arm;     // new armed flag for that cell
        logic [SLOT_W-1:0] slot;    // addressed cell
        logic [TICK_W-1:0] target;  // new target tick
        logic              shift;   // token moves one cell on
    } t_cell_cmd;

endpackage

// File: src/msta_cell.sv
// ----------------------------------------------------------------------------
// msta_cell
// One alarm slot: armed flag, target tick and a stage of the scan token chain.
// ----------------------------------------------------------------------------
module msta_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  msta_pkg::t_cell_cmd         i_cmd,
    input  logic [msta_pkg::TICK_W-1:0] i_cnt,
    input  logic                        i_tok,
    output logic                        o_tok,
    output logic                        o_hit
);
    import msta_pkg::*;

    logic              r_armed;
    logic              n_armed;
    logic [TICK_W-1:0] r_target;
    logic              r_tok;
    logic [TICK_W-1:0] w_diff;
    logic              w_sel;

    assign w_sel  = i_cmd.wr && (i_cmd.slot == SLOT_W'(IDX));
    // reached when the modular difference is not negative
    assign w_diff = i_cnt - r_target;
    assign o_hit  = r_tok && r_armed && !w_diff[TICK_W-1];
    assign o_tok  = r_tok;

    always_comb begin
        n_armed = r_armed;
        if (w_sel) begin
            n_armed = i_cmd.arm;
        end else if (i_cmd.shift && o_hit) begin
            n_armed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_armed <= n_armed;
            if (i_cmd.shift) begin
                r_tok <= i_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_target <= i_cmd.target;
        end
    end

endmodule

// File: src/multi_slot_tick_alarm.sv
// arm item: a zero delay puts its wake item in the output register
// tick item: a token walks the slot cells, one cell per cycle unless a hit must wait for
// the output register to take the held item; each wake item leaves one hit later than
// found (held so the last one can be flagged), the final one at the end of the walk
// next item is accepted once the walk is over and the output register can take data
// reset (synchronous, active low): counter zero, all slots disarmed, output empty
// ----------------------------------------------------------------------------
// multi_slot_tick_alarm
// Tick counter, advanced by each tick item, with a row of compare slots; fired
// slots are reported in slot order after each tick.
// ----------------------------------------------------------------------------
module multi_slot_tick_alarm #(
    parameter int NUM_SLOTS = msta_pkg::NUM_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_op,
    input  logic [msta_pkg::SLOT_W-1:0]  i_slot,
    input  logic [msta_pkg::DELAY_W-1:0] i_delay,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [msta_pkg::SLOT_W-1:0]  o_woken_slot,
    output logic [msta_pkg::TICK_W-1:0]  o_now_tick,
    output logic                         o_is_last
);
    import msta_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [TICK_W-1:0] r_cnt;
    logic [IDX_W-1:0]  r_idx;
    logic              r_pend_valid;
    logic [SLOT_W-1:0] r_pend_slot;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic [TICK_W-1:0] r_out_tick;
    logic              r_out_last;

    t_cell_cmd            w_cmd;
    logic [NUM_SLOTS:0]   w_tok;
    logic [NUM_SLOTS-1:0] w_hit;
    logic                 w_any_hit;
    logic                 w_out_free;
    logic                 w_acc;
    logic                 w_in_range;
    logic                 w_start;
    logic                 w_adv;
    logic                 w_end;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_in_range = {1'b0, i_slot} < (SLOT_W + 1)'(NUM_SLOTS);
    assign w_start    = w_acc && (i_op == OP_TICK);
    assign w_any_hit  = |w_hit;
    // a hit needs the holding register free, or room to push the held item out
    assign w_adv      = (r_state == ST_SCAN) && (!w_any_hit || !r_pend_valid || w_out_free);
    assign w_end      = r_idx == IDX_W'(NUM_SLOTS - 1);

    always_comb begin
        w_cmd.wr     = w_acc && (i_op == OP_ARM) && w_in_range;
        w_cmd.arm    = i_delay != '0;
        w_cmd.slot   = i_slot;
        w_cmd.target = r_cnt + TICK_W'(i_delay);
        w_cmd.shift  = w_start || w_adv;
    end

    assign w_tok[0] = w_start;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        msta_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_cnt   (r_cnt),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_hit   (w_hit[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_adv && w_end) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_cnt <= r_cnt + 1'b1;
                r_idx <= '0;
            end else if (w_adv) begin
                r_idx <= r_idx + 1'b1;
            end

            if (w_adv && w_any_hit) begin
                r_pend_valid <= 1'b1;
            end else if (r_state == ST_FLUSH && w_out_free) begin
                r_pend_valid <= 1'b0;
            end

            if (w_acc && i_op == OP_ARM && w_in_range && i_delay == '0) begin
                r_out_valid <= 1'b1;
            end else if (w_adv && w_any_hit && r_pend_valid) begin
                r_out_valid <= 1'b1;
            end else if (r_state == ST_FLUSH && r_pend_valid && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the holding and output registers
    always_ff @(posedge i_clk) begin
        if (w_adv && w_any_hit) begin
            r_pend_slot <= SLOT_W'(r_idx);
        end
        if (w_acc && i_op == OP_ARM && w_in_range && i_delay == '0) begin
            r_out_slot <= i_slot;
            r_out_tick <= r_cnt;
            r_out_last <= 1'b1;
        end else if (w_adv && w_any_hit && r_pend_valid) begin
            r_out_slot <= r_pend_slot;
            r_out_tick <= r_cnt;
            r_out_last <= 1'b0;
        end else if (r_state == ST_FLUSH && r_pend_valid && w_out_free) begin
            r_out_slot <= r_pend_slot;
            r_out_tick <= r_cnt;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_woken_slot = r_out_slot;
    assign o_now_tick   = r_out_tick;
    assign o_is_last    = r_out_last;

endmodule

// File: test/multi_slot_tick_alarm_tb.sv
// ----------------------------------------------------------------------------
// multi_slot_tick_alarm_tb
// Drives arm and tick items into the alarm bank, checks every wake item
// against a local model of the counter and slots, with random gaps on both
// sides, a long output hold-off and a full-bank burst.
// ----------------------------------------------------------------------------
module multi_slot_tick_alarm_tb;
    import msta_pkg::*;

    localparam int N_SLOTS     = NUM_SLOTS_DEF;
    localparam int N_RANDOM    = 240;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int IDLE_PCT    = 23;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] now;
        logic              last;
    } t_wake;

    typedef struct packed {
        logic               op;
        logic [SLOT_W-1:0]  slot;
        logic [DELAY_W-1:0] dly;
        logic               typed;
        t_wake              want;
    } t_row;

    // counter runs 0,1,2,... through the opening rows; typed rows are the obvious ones
    localparam t_row OPENING_ROWS [0:24] = '{
        '{OP_ARM,  6'd0,  16'd0,     1'b1, '{6'd0,  32'd0, 1'b1}},
        '{OP_ARM,  6'd63, 16'd0,     1'b1, '{6'd63, 32'd0, 1'b1}},
        '{OP_TICK, 6'd0,  16'd0,     1'b0, '0},
        '{OP_ARM,  6'd63, 16'd65535, 1'b0, '0},
        '{OP_ARM,  6'd5,  16'd1,     1'b0, '0},
        '{OP_TICK, 6'd17, 16'd999,   1'b0, '0},
        '{OP_ARM,  6'd1,  16'd2,     1'b0, '0},
        '{OP_ARM,  6'd2,  16'd2,     1'b0, '0},
        '{OP_ARM,  6'd3,  16'd2,     1'b0, '0},
        '{OP_ARM,  6'd2,  16'd1,     1'b0, '0},
        '{OP_TICK, 6'd0,  16'd0,     1'b0, '0},
        '{OP_TICK, 6'd63, 16'd65535, 1'b0, '0},
        '{OP_ARM,  6'd40, 16'd3,     1'b0, '0},
        '{OP_ARM,  6'd40, 16'd0,     1'b1, '{6'd40, 32'd4, 1'b1}},
        '{OP_TICK, 6'd0,  16'd0,     1'b0, '0},
        '{OP_TICK, 6'd0,  16'd0,     1'b0, '0},
        '{OP_TICK, 6'd0,  16'd0,     1'b0, '0},
        '{OP_ARM,  6'd42, 16'd21845, 1'b0, '0},
        '{OP_ARM,  6'd21, 16'd43690, 1'b0, '0},
        '{OP_ARM,  6'd0,  16'd1,     1'b0, '0},
        '{OP_ARM,  6'd31, 16'd1,     1'b0, '0},
        '{OP_ARM,  6'd32, 16'd1,     1'b0, '0},
        '{OP_ARM,  6'd63, 16'd1,     1'b0, '0},
        '{OP_TICK, 6'd0,  16'd0,     1'b0, '0},
        '{OP_TICK, 6'd0,  16'd0,     1'b0, '0}
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               i_op        = OP_TICK;
    logic [SLOT_W-1:0]  i_slot      = '0;
    logic [DELAY_W-1:0] i_delay     = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [SLOT_W-1:0]  o_woken_slot;
    logic [TICK_W-1:0]  o_now_tick;
    logic               o_is_last;

    multi_slot_tick_alarm #(
        .NUM_SLOTS(N_SLOTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_slot      (i_slot),
        .i_delay     (i_delay),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_woken_slot(o_woken_slot),
        .o_now_tick  (o_now_tick),
        .o_is_last   (o_is_last)
    );

    always #10 i_clk = ~i_clk;

    // local copy of the alarm bank
    logic [TICK_W-1:0] tick_now;
    logic              slot_armed [N_SLOTS];
    logic [TICK_W-1:0] slot_due   [N_SLOTS];

    t_wake wake_q[$];
    t_wake fresh_wakes[$];
    int    mismatches   = 0;
    int    idle_cycles  = 0;
    bit    calm         = 1'b0;
    bit    hold_out_req = 1'b0;

    function automatic void clear_alarm_bank();
        tick_now = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            slot_armed[i] = 1'b0;
            slot_due[i]   = '0;
        end
    endfunction

    // fills fresh_wakes with the wake items one accepted item gives
    function automatic void predict_wakes(input logic op, input logic [SLOT_W-1:0] slot,
                                          input logic [DELAY_W-1:0] dly);
        logic [TICK_W-1:0] gap;
        t_wake             held;
        bit                have_held;
        fresh_wakes.delete();
        have_held = 1'b0;
        held      = '0;
        if (op == OP_ARM) begin
            if (int'(slot) >= N_SLOTS) return;
            if (dly == '0) begin
                slot_armed[slot] = 1'b0;
                held.slot = slot;
                held.now  = tick_now;
                held.last = 1'b1;
                fresh_wakes.push_back(held);
            end else begin
                slot_due[slot]   = tick_now + TICK_W'(dly);
                slot_armed[slot] = 1'b1;
            end
        end else begin
            tick_now = tick_now + 1'b1;
            for (int i = 0; i < N_SLOTS; i++) begin
                // reached when the modular difference is not negative
                gap = tick_now - slot_due[i];
                if (slot_armed[i] && !gap[TICK_W-1]) begin
                    if (have_held) fresh_wakes.push_back(held);
                    held.slot     = SLOT_W'(i);
                    held.now      = tick_now;
                    held.last     = 1'b0;
                    have_held     = 1'b1;
                    slot_armed[i] = 1'b0;
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                fresh_wakes.push_back(held);
            end
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    // called at a rising edge, returns at the edge where the item is taken
    task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                             input logic [DELAY_W-1:0] dly);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_slot     <= slot;
        i_delay    <= dly;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
    endtask

    task automatic offer(input logic op, input logic [SLOT_W-1:0] slot,
                         input logic [DELAY_W-1:0] dly);
        send_item(op, slot, dly);
        predict_wakes(op, slot, dly);
        foreach (fresh_wakes[j]) wake_q.push_back(fresh_wakes[j]);
    endtask

    // receiver side
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_out_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out_req = 1'b0;
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // outputs and handshakes are sampled mid-cycle, away from the driving edge
    always @(negedge i_clk) begin : wake_monitor
        t_wake got;
        t_wake want;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (o_out_valid && i_out_ready) begin
                got.slot = o_woken_slot;
                got.now  = o_now_tick;
                got.last = o_is_last;
                if (wake_q.size() == 0) begin
                    note_failure($sformatf("unexpected wake item: slot %0d tick %0d last %0b",
                                           got.slot, got.now, got.last));
                end else begin
                    want = wake_q.pop_front();
                    if (got !== want)
                        note_failure($sformatf({"wake item mismatch: expected slot %0d ",
                                                "tick %0d last %0b, got slot %0d tick %0d ",
                                                "last %0b"}, want.slot, want.now, want.last,
                                               got.slot, got.now, got.last));
                end
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(negedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_row               row;
        logic               op;
        logic [SLOT_W-1:0]  slot;
        logic [DELAY_W-1:0] dly;
        int                 pick;
        clear_alarm_bank();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (OPENING_ROWS[k]) begin
            row = OPENING_ROWS[k];
            send_item(row.op, row.slot, row.dly);
            predict_wakes(row.op, row.slot, row.dly);
            if (row.typed) wake_q.push_back(row.want);
            else foreach (fresh_wakes[j]) wake_q.push_back(fresh_wakes[j]);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // every slot due on the same tick: the longest run of wake items
            if (n == 40) begin
                for (int s = 0; s < N_SLOTS; s++) offer(OP_ARM, SLOT_W'(s), 16'd1);
                offer(OP_TICK, SLOT_W'($urandom), DELAY_W'($urandom));
            end
            if (n == 100) hold_out_req = 1'b1;
            if (n == 160) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (wake_q.size() != 0) @(posedge i_clk);
            end
            calm = (n >= 180 && n < 230);

            slot = SLOT_W'($urandom);
            dly  = DELAY_W'($urandom);
            op   = ($urandom_range(99) < 40) ? OP_TICK : OP_ARM;
            if (n >= 100 && n < 130) begin
                // immediate wakes pile up behind the held output
                op  = OP_ARM;
                dly = '0;
            end else if (op == OP_ARM) begin
                pick = $urandom_range(99);
                if (pick < 15)      dly = '0;
                else if (pick < 75) dly = DELAY_W'($urandom_range(6, 1));
                else if (pick < 90) dly = DELAY_W'($urandom_range(40, 7));
            end
            offer(op, slot, dly);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (wake_q.size() != 0) @(posedge i_clk);
        repeat (2 * N_SLOTS + 10) @(posedge i_clk);
        if (mismatches == 0 && wake_q.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
src/msta_pkg.sv
src/msta_cell.sv
src/multi_slot_tick_alarm.sv
test/multi_slot_tick_alarm_tb.sv
